FILE: rtl/disparity_band_mask_change_ratio_defines.svh
// Assertion macros shared by the disparity band mask modules.
`ifndef DISPARITY_BAND_MASK_CHANGE_RATIO_DEFINES_SVH
`define DISPARITY_BAND_MASK_CHANGE_RATIO_DEFINES_SVH

// Check cons in the same cycle as ante.
`define DBMCR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define DBMCR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/dbmcr_pkg.sv
// Shared widths, constants, register codes and controller interface types.
package dbmcr_pkg;

   localparam int PIX_W      = 8;
   localparam int COL_W      = 10;
   localparam int ROW_W      = 9;
   localparam int CNT_W      = 19;
   localparam int FRAC_W     = 16;
   localparam int RATIO_W    = CNT_W + FRAC_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam int DEF_MAX_WIDTH  = 640;
   localparam int DEF_MAX_HEIGHT = 480;

   localparam int BORDER     = 30;
   localparam int DIFF_LIMIT = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_HALF_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd3;

   localparam logic [PIX_W-1:0] RST_HALF_WIDTH   = 8'd50;
   localparam logic [PIX_W-1:0] RST_LEVEL        = 8'd80;
   localparam logic [COL_W-1:0] RST_FRAME_WIDTH  = 10'd320;
   localparam logic [ROW_W-1:0] RST_FRAME_HEIGHT = 9'd240;

   typedef struct packed {
      logic clear_en;
      logic accept;
      logic exec;
      logic div_start;
      logic load_out;
   } dbmcr_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic need_div;
      logic div_done;
      logic out_free;
   } dbmcr_sts_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

endpackage

FILE: rtl/dbmcr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dbmcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/dbmcr_div.sv
// Restoring divider, one quotient bit per cycle, for the fixed-point change ratio.
module dbmcr_div import dbmcr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [CNT_W-1:0]   numer,
   input  logic [CNT_W-1:0]   denom,
   output logic [RATIO_W-1:0] quotient,
   output logic               done
);

   localparam int StepW = $clog2(RATIO_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [StepW-1:0]   step_ff, step_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [RATIO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]   den_ff, den_in;

   logic [CNT_W:0]     trial;
   logic [CNT_W:0]     diff;
   logic               fits;

   assign trial = {rem_ff, quo_ff[RATIO_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = StepW'(RATIO_W - 1);
         rem_in  = '0;
         quo_in  = {numer, FRAC_W'(0)};
         den_in  = denom;
      end else if (busy_ff) begin
         rem_in = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_in = {quo_ff[RATIO_W-2:0], fits};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

FILE: rtl/dbmcr_ctrl.sv
// Controller state machine: store clearing, pixel sequencing, division wait, result handoff.
`include "disparity_band_mask_change_ratio_defines.svh"
module dbmcr_ctrl import dbmcr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output dbmcr_cmd_type cmd,
   input  dbmcr_sts_type sts
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   `DBMCR_ASSERT_NEXT(a_no_reclear, state_ff != S_CLEAR, state_ff != S_CLEAR, "store clear re-entered")
   `DBMCR_ASSERT_NEXT(a_div_exit, state_ff == S_DIV, state_ff == S_DIV || state_ff == S_DONE, "bad exit from division wait")
   `DBMCR_ASSERT_SAME(a_exec_after_accept, state_ff == S_EXEC, $past(state_ff) == S_IDLE, "exec without accept")

endmodule

FILE: rtl/dbmcr_datapath.sv
// Datapath: registers, counters, band and border mask, reference store, accumulators, output register.
`include "disparity_band_mask_change_ratio_defines.svh"
module dbmcr_datapath import dbmcr_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dbmcr_cmd_type         cmd,
   output dbmcr_sts_type         sts,
   input  logic                  req_command,
   input  logic [PIX_W-1:0]      req_disparity,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_masked_pixel,
   output logic                  rsp_frame_end,
   output logic [CNT_W-1:0]      rsp_changed_count,
   output logic [CNT_W-1:0]      rsp_reference_total,
   output logic [RATIO_W-1:0]    rsp_change_ratio,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
   localparam int AddrW = $clog2(Depth);

   logic [PIX_W-1:0]   half_width_ff;
   logic [PIX_W-1:0]   level_ff;
   logic [COL_W-1:0]   frame_width_ff;
   logic [ROW_W-1:0]   frame_height_ff;

   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [CNT_W-1:0]   changed_ff, changed_in;
   logic [CNT_W-1:0]   refcnt_ff, refcnt_in;
   logic [AddrW-1:0]   clear_addr_ff;

   logic               cmd_ff;
   logic [PIX_W-1:0]   disp_ff;
   logic [AddrW-1:0]   addr_ff;

   logic [PIX_W-1:0]   pend_masked_ff;
   logic               pend_end_ff;
   logic [CNT_W-1:0]   pend_changed_ff;
   logic [CNT_W-1:0]   pend_total_ff;
   logic               pend_div_ff;

   logic               rsp_valid_ff;
   logic [PIX_W-1:0]   rsp_masked_ff;
   logic               rsp_end_ff;
   logic [CNT_W-1:0]   rsp_changed_ff;
   logic [CNT_W-1:0]   rsp_total_ff;
   logic [RATIO_W-1:0] rsp_ratio_ff;

   logic [COL_W-1:0]   w_use;
   logic [ROW_W-1:0]   h_use;
   logic [AddrW-1:0]   rd_addr;
   logic [PIX_W-1:0]   ref_pix;
   logic               in_band;
   logic               border;
   logic [PIX_W-1:0]   masked;
   logic [PIX_W-1:0]   abs_diff;
   logic [CNT_W-1:0]   refcnt_dec;
   logic               row_end;
   logic               frame_end;
   logic               ram_wr_en;
   logic [AddrW-1:0]   ram_wr_addr;
   logic [PIX_W-1:0]   ram_wr_data;
   logic [RATIO_W-1:0] quotient;
   logic               div_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff   <= RST_HALF_WIDTH;
         level_ff        <= RST_LEVEL;
         frame_width_ff  <= RST_FRAME_WIDTH;
         frame_height_ff <= RST_FRAME_HEIGHT;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_HALF_WIDTH:   half_width_ff   <= csr_data[PIX_W-1:0];
            CSR_LEVEL:        level_ff        <= csr_data[PIX_W-1:0];
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[COL_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   always_comb begin
      if (frame_width_ff == '0) begin
         w_use = COL_W'(1);
      end else if (int'(frame_width_ff) > MAX_WIDTH) begin
         w_use = COL_W'(MAX_WIDTH);
      end else begin
         w_use = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         h_use = ROW_W'(1);
      end else if (int'(frame_height_ff) > MAX_HEIGHT) begin
         h_use = ROW_W'(MAX_HEIGHT);
      end else begin
         h_use = frame_height_ff;
      end
   end

   assign rd_addr = AddrW'(int'(row_ff) * MAX_WIDTH + int'(col_ff));

   assign in_band = (({1'b0, disp_ff} + {1'b0, half_width_ff}) > {1'b0, level_ff}) &&
                    ({1'b0, disp_ff} <= ({1'b0, level_ff} + {1'b0, half_width_ff}));

   assign border = (col_ff < COL_W'(BORDER)) ||
                   (({1'b0, col_ff} + (COL_W+1)'(BORDER)) > {1'b0, w_use}) ||
                   (row_ff < ROW_W'(BORDER)) ||
                   (({1'b0, row_ff} + (ROW_W+1)'(BORDER)) > {1'b0, h_use});

   assign masked   = (in_band && !border) ? disp_ff : '0;
   assign abs_diff = (ref_pix > masked) ? ref_pix - masked : masked - ref_pix;

   assign row_end   = ({1'b0, col_ff} + 1'b1) >= {1'b0, w_use};
   assign frame_end = row_end && (({1'b0, row_ff} + 1'b1) >= {1'b0, h_use});

   always_comb begin
      changed_in = changed_ff;
      refcnt_in  = refcnt_ff;
      refcnt_dec = refcnt_ff;
      if (cmd_ff) begin
         if (ref_pix != '0 && refcnt_ff != '0) begin
            refcnt_dec = refcnt_ff - 1'b1;
         end
         refcnt_in = (masked != '0) ? sat_inc(refcnt_dec) : refcnt_dec;
      end else if (abs_diff > PIX_W'(DIFF_LIMIT)) begin
         changed_in = sat_inc(changed_ff);
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (row_end) begin
         col_in = '0;
         row_in = frame_end ? '0 : row_ff + 1'b1;
      end else begin
         col_in = col_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         changed_ff    <= '0;
         refcnt_ff     <= '0;
         clear_addr_ff <= '0;
      end else begin
         if (cmd.clear_en) begin
            clear_addr_ff <= clear_addr_ff + 1'b1;
         end
         if (cmd.exec) begin
            col_ff     <= col_in;
            row_ff     <= row_in;
            changed_ff <= frame_end ? '0 : changed_in;
            refcnt_ff  <= refcnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff  <= req_command;
         disp_ff <= req_disparity;
         addr_ff <= rd_addr;
      end
      if (cmd.exec) begin
         pend_masked_ff  <= masked;
         pend_end_ff     <= frame_end;
         pend_changed_ff <= frame_end ? changed_in : '0;
         pend_total_ff   <= refcnt_in;
         pend_div_ff     <= frame_end && (refcnt_in != '0);
      end
   end

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = masked;
      if (cmd.clear_en) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_addr_ff;
         ram_wr_data = '0;
      end else if (cmd.exec && cmd_ff) begin
         ram_wr_en = 1'b1;
      end
   end

   dbmcr_ram #(
      .WIDTH (PIX_W),
      .DEPTH (Depth)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (rd_addr),
      .rd_data (ref_pix)
   );

   dbmcr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .numer    (changed_in),
      .denom    (refcnt_in),
      .quotient (quotient),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_masked_ff  <= pend_masked_ff;
         rsp_end_ff     <= pend_end_ff;
         rsp_changed_ff <= pend_changed_ff;
         rsp_total_ff   <= pend_total_ff;
         rsp_ratio_ff   <= pend_div_ff ? quotient : '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_masked_pixel    = rsp_masked_ff;
   assign rsp_frame_end       = rsp_end_ff;
   assign rsp_changed_count   = rsp_changed_ff;
   assign rsp_reference_total = rsp_total_ff;
   assign rsp_change_ratio    = rsp_ratio_ff;

   assign sts.clear_last = (clear_addr_ff == AddrW'(Depth - 1));
   assign sts.need_div   = frame_end && (refcnt_in != '0);
   assign sts.div_done   = div_done;
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   `DBMCR_ASSERT_NEXT(a_refcnt_hold, !cmd.exec, $stable(refcnt_ff), "reference count moved without a pixel")
   `DBMCR_ASSERT_NEXT(a_accum_cleared, cmd.exec && frame_end, changed_ff == '0, "change count not cleared at frame end")
   `DBMCR_ASSERT_SAME(a_no_overwrite, cmd.load_out && rsp_valid_ff, !rsp_stall, "result overwritten while stalled")

endmodule

FILE: rtl/disparity_band_mask_change_ratio.sv
// Top level of the disparity band mask with frame-difference change ratio.
// Pixels arrive in raster order, one per request; each yields one result with the
// band and border masked pixel, the reference count and, on the last pixel of a
// frame, the changed count and the unsigned 19.16 change ratio. After reset the
// reference store (MAX_WIDTH*MAX_HEIGHT bytes, 307200 at the defaults) is cleared
// one byte per cycle, with req_stall held high until it is done; configuration
// writes are taken throughout. A pixel then goes from acceptance to the next
// acceptance through the registered read of the reference store, the update
// stage and the result stage, which waits until the output register is free.
// The last pixel of a frame with a nonzero reference count also waits for the
// ratio from a divider producing one quotient bit per cycle. A finished result
// waits in the output register, and the next pixel is accepted while it waits.
module disparity_band_mask_change_ratio import dbmcr_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic [PIX_W-1:0]      req_disparity,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_masked_pixel,
   output logic                  rsp_frame_end,
   output logic [CNT_W-1:0]      rsp_changed_count,
   output logic [CNT_W-1:0]      rsp_reference_total,
   output logic [RATIO_W-1:0]    rsp_change_ratio,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   dbmcr_cmd_type cmd;
   dbmcr_sts_type sts;

   dbmcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   dbmcr_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_command         (req_command),
      .req_disparity       (req_disparity),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_masked_pixel    (rsp_masked_pixel),
      .rsp_frame_end       (rsp_frame_end),
      .rsp_changed_count   (rsp_changed_count),
      .rsp_reference_total (rsp_reference_total),
      .rsp_change_ratio    (rsp_change_ratio),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

endmodule

FILE: tb/sv/disparity_band_mask_change_ratio_checker.sv
// Checker for the disparity band mask: predicts each result, compares it and counts failures.
module disparity_band_mask_change_ratio_checker import dbmcr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_command,
   input  logic [PIX_W-1:0]      req_disparity,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [PIX_W-1:0]      rsp_masked_pixel,
   input  logic                  rsp_frame_end,
   input  logic [CNT_W-1:0]      rsp_changed_count,
   input  logic [CNT_W-1:0]      rsp_reference_total,
   input  logic [RATIO_W-1:0]    rsp_change_ratio,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    errors,
   output int                    pending,
   output int                    frame_reports
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
   localparam int CNT_SAT     = (1 << CNT_W) - 1;
   localparam int MAX_REPORTS = 100;
   localparam int EXP_DEPTH   = 16;

   typedef struct packed {
      logic [PIX_W-1:0]   masked_pixel;
      logic               frame_end;
      logic [CNT_W-1:0]   changed_count;
      logic [CNT_W-1:0]   reference_total;
      logic [RATIO_W-1:0] change_ratio;
   } pixel_result_type;

   logic [PIX_W-1:0] half_width;
   logic [PIX_W-1:0] level;
   logic [COL_W-1:0] frame_width;
   logic [ROW_W-1:0] frame_height;

   int col;
   int row;
   int changed;
   int ref_count;
   bit [PIX_W-1:0] ref_store [STORE_DEPTH];
   pixel_result_type expected_pixels [EXP_DEPTH];
   int exp_head;
   int exp_count;

   task automatic mask_pixel(input logic cmd, input logic [PIX_W-1:0] disp,
                             output pixel_result_type res);
      int w, h, lo, hi, d, masked, addr, refv, diff;
      bit row_end, fend;
      w = int'(frame_width);
      h = int'(frame_height);
      if (w < 1) w = 1;
      if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
      if (h < 1) h = 1;
      if (h > DEF_MAX_HEIGHT) h = DEF_MAX_HEIGHT;
      lo = int'(level) - int'(half_width);
      hi = int'(level) + int'(half_width);
      d = int'(disp);
      masked = (d > lo && d <= hi) ? d : 0;
      if (col < BORDER || col > w - BORDER || row < BORDER || row > h - BORDER)
         masked = 0;
      if (col < DEF_MAX_WIDTH && row < DEF_MAX_HEIGHT) begin
         addr = row * DEF_MAX_WIDTH + col;
         refv = int'(ref_store[addr]);
         if (cmd) begin
            if (refv != 0 && ref_count > 0) ref_count--;
            if (masked != 0 && ref_count < CNT_SAT) ref_count++;
            ref_store[addr] = PIX_W'(masked);
         end else begin
            diff = (refv > masked) ? refv - masked : masked - refv;
            if (diff > DIFF_LIMIT && changed < CNT_SAT) changed++;
         end
      end
      row_end = (col >= w - 1);
      fend = row_end && (row >= h - 1);
      res = '0;
      res.masked_pixel = PIX_W'(masked);
      res.frame_end = fend;
      if (fend) begin
         res.changed_count = CNT_W'(changed);
         if (ref_count != 0)
            res.change_ratio = RATIO_W'((longint'(changed) << FRAC_W) / longint'(ref_count));
         changed = 0;
      end
      res.reference_total = CNT_W'(ref_count);
      if (row_end) begin
         col = 0;
         row = fend ? 0 : (row + 1) & ((1 << ROW_W) - 1);
      end else begin
         col = (col + 1) & ((1 << COL_W) - 1);
      end
   endtask

   task automatic check_field(input string name, input logic [RATIO_W-1:0] want,
                              input logic [RATIO_W-1:0] seen);
      if (seen !== want) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, seen);
      end
   endtask

   always @(posedge clock) begin
      pixel_result_type predicted;
      pixel_result_type want_res;
      if (reset) begin
         half_width = RST_HALF_WIDTH;
         level = RST_LEVEL;
         frame_width = RST_FRAME_WIDTH;
         frame_height = RST_FRAME_HEIGHT;
         col = 0;
         row = 0;
         changed = 0;
         ref_count = 0;
         foreach (ref_store[i]) ref_store[i] = '0;
         exp_head = 0;
         exp_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HALF_WIDTH:   half_width = csr_data[PIX_W-1:0];
               CSR_LEVEL:        level = csr_data[PIX_W-1:0];
               CSR_FRAME_WIDTH:  frame_width = csr_data[COL_W-1:0];
               CSR_FRAME_HEIGHT: frame_height = csr_data[ROW_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (exp_count == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t ns: result with no request waiting", $time);
            end else begin
               want_res = expected_pixels[exp_head];
               exp_head = (exp_head + 1) % EXP_DEPTH;
               exp_count--;
               check_field("masked_pixel", RATIO_W'(want_res.masked_pixel),
                           RATIO_W'(rsp_masked_pixel));
               check_field("frame_end", RATIO_W'(want_res.frame_end),
                           RATIO_W'(rsp_frame_end));
               check_field("changed_count", RATIO_W'(want_res.changed_count),
                           RATIO_W'(rsp_changed_count));
               check_field("reference_total", RATIO_W'(want_res.reference_total),
                           RATIO_W'(rsp_reference_total));
               check_field("change_ratio", want_res.change_ratio, rsp_change_ratio);
               if (want_res.frame_end) frame_reports++;
            end
         end
         if (req_valid && !req_stall) begin
            mask_pixel(req_command, req_disparity, predicted);
            if (exp_count == EXP_DEPTH) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t ns: more than %0d requests in flight", $time, EXP_DEPTH);
            end else begin
               expected_pixels[(exp_head + exp_count) % EXP_DEPTH] = predicted;
               exp_count++;
            end
         end
      end
      pending <= exp_count;
   end

endmodule

FILE: tb/sv/disparity_band_mask_change_ratio_test.sv
// Testbench top: drives pixel and register traffic into the disparity band mask.
module disparity_band_mask_change_ratio_test;
   timeunit 1ns;
   timeprecision 1ps;
   import dbmcr_pkg::*;

   localparam int SCENE_SIZE    = 4096;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 60;

   typedef enum {FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH} flow_type;
   typedef enum {FILL_CAPTURE, FILL_PROCESS, FILL_MIXED} fill_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_command;
   logic [PIX_W-1:0]      req_disparity;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PIX_W-1:0]      rsp_masked_pixel;
   logic                  rsp_frame_end;
   logic [CNT_W-1:0]      rsp_changed_count;
   logic [CNT_W-1:0]      rsp_reference_total;
   logic [RATIO_W-1:0]    rsp_change_ratio;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int errors;
   int pending;
   int frame_reports;

   flow_type flow_mode = FLOW_FREE;
   logic  hold_req = 1'b0;
   logic  hold_ack = 1'b0;
   int    hold_left = 0;

   int pos_col;
   int pos_row;
   int cur_w;
   int cur_h;
   int band_lo;
   int band_hi;
   int requests_sent;
   logic [PIX_W-1:0] scene [SCENE_SIZE];
   logic [PIX_W-1:0] opening_px [24] = '{8'd0, 8'd255, 8'd1, 8'd254, 8'h55, 8'hAA,
                                         8'd30, 8'd31, 8'd130, 8'd131, 8'd80, 8'd79,
                                         8'd81, 8'd128, 8'd127, 8'd2, 8'd253, 8'h0F,
                                         8'hF0, 8'd10, 8'd11, 8'd255, 8'd0, 8'd129};

   disparity_band_mask_change_ratio dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_disparity       (req_disparity),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_masked_pixel    (rsp_masked_pixel),
      .rsp_frame_end       (rsp_frame_end),
      .rsp_changed_count   (rsp_changed_count),
      .rsp_reference_total (rsp_reference_total),
      .rsp_change_ratio    (rsp_change_ratio),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   disparity_band_mask_change_ratio_checker ratio_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_disparity       (req_disparity),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_masked_pixel    (rsp_masked_pixel),
      .rsp_frame_end       (rsp_frame_end),
      .rsp_changed_count   (rsp_changed_count),
      .rsp_reference_total (rsp_reference_total),
      .rsp_change_ratio    (rsp_change_ratio),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .errors              (errors),
      .pending             (pending),
      .frame_reports       (frame_reports)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // hold off for a long stretch on request, else stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_ack <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_req != hold_ack) begin
         hold_ack <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= $urandom_range(0, 99) < ((flow_mode == FLOW_RECEIVER_STALL) ? 68 :
                                               (flow_mode == FLOW_BOTH) ? 14 : 0);
      end
   end

   function automatic logic [PIX_W-1:0] clip_pixel(input int v);
      return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : PIX_W'(v);
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input int hw, input int lvl, input int w, input int h);
      write_reg(CSR_HALF_WIDTH, hw);
      write_reg(CSR_LEVEL, lvl);
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
      csr_valid <= 1'b0;
      band_lo = lvl - hw;
      band_hi = lvl + hw;
      cur_w = w;
      cur_h = h;
   endtask

   task automatic draw_scene();
      int r, v;
      for (int i = 0; i < SCENE_SIZE; i++) begin
         r = $urandom_range(0, 99);
         if (r < 15) v = band_lo;
         else if (r < 30) v = band_lo + 1;
         else if (r < 45) v = band_hi;
         else if (r < 60) v = band_hi + 1;
         else if (r < 68) v = 0;
         else if (r < 76) v = 255;
         else v = $urandom_range(int'(clip_pixel(band_lo - 5)), int'(clip_pixel(band_hi + 5)));
         scene[i] = clip_pixel(v);
      end
   endtask

   task automatic pixel_for(input fill_type kind, output logic cmd,
                            output logic [PIX_W-1:0] disp);
      int base, r;
      base = int'(scene[(pos_row * 67 + pos_col) % SCENE_SIZE]);
      case (kind)
         FILL_CAPTURE: cmd = 1'b1;
         FILL_PROCESS: cmd = 1'b0;
         default:      cmd = 1'($urandom_range(0, 1));
      endcase
      r = $urandom_range(0, 99);
      if (cmd || r < 50) disp = clip_pixel(base + int'($urandom_range(0, 20)) - 10);
      else if (r < 80) disp = clip_pixel(base + int'($urandom_range(0, 80)) - 40);
      else disp = PIX_W'($urandom_range(0, 255));
      if (cmd && r < 60) disp = PIX_W'(base);
   endtask

   task automatic send_pixel(input logic cmd, input logic [PIX_W-1:0] disp);
      while ($urandom_range(0, 99) < ((flow_mode == FLOW_SENDER_IDLE) ? 68 :
                                      (flow_mode == FLOW_BOTH) ? 14 : 0)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_disparity <= disp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
      if (pos_col >= cur_w - 1) begin
         pos_col = 0;
         pos_row = (pos_row >= cur_h - 1) ? 0 : pos_row + 1;
      end else begin
         pos_col++;
      end
   endtask

   task automatic send_pixels(input fill_type kind, input int count, input flow_type mode);
      logic cmd;
      logic [PIX_W-1:0] disp;
      flow_mode <= mode;
      repeat (count) begin
         pixel_for(kind, cmd, disp);
         send_pixel(cmd, disp);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // step down the border rows one row per request, run two interior rows, close the frame
   task automatic run_frame(input int hw, input int lvl, input int width, input fill_type kind,
                            input flow_type mode, input bit fresh_scene, input bit long_hold);
      configure(hw, lvl, 1, DEF_MAX_HEIGHT);
      if (fresh_scene) draw_scene();
      send_pixels(kind, BORDER, mode);
      settle();
      configure(hw, lvl, width, 2 * BORDER + 1);
      if (long_hold) hold_req <= ~hold_req;
      send_pixels(kind, 2 * width, mode);
      settle();
      configure(hw, lvl, 1, 1);
      send_pixels(kind, 1, mode);
      settle();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = 1'b0;
      req_disparity = '0;
      csr_valid = 1'b0;
      csr_index = CSR_HALF_WIDTH;
      csr_data = '0;
      pos_col = 0;
      pos_row = 0;
      cur_w = int'(RST_FRAME_WIDTH);
      cur_h = int'(RST_FRAME_HEIGHT);
      band_lo = int'(RST_LEVEL) - int'(RST_HALF_WIDTH);
      band_hi = int'(RST_LEVEL) + int'(RST_HALF_WIDTH);
      requests_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_px[i]) send_pixel(1'(i % 2), opening_px[i]);
      settle();

      // shrink the frame under running counters: report on an empty reference
      configure(int'(RST_HALF_WIDTH), int'(RST_LEVEL), 1, 1);
      send_pixels(FILL_PROCESS, 1, FLOW_FREE);
      settle();

      run_frame(20, 100, 80, FILL_CAPTURE, FLOW_SENDER_IDLE, 1'b1, 1'b0);
      // hold the result side while requests keep coming
      run_frame(20, 100, 80, FILL_PROCESS, FLOW_RECEIVER_STALL, 1'b0, 1'b1);
      run_frame(255, 1, 70, FILL_MIXED, FLOW_BOTH, 1'b1, 1'b0);
      // empty band: capture clears the reference
      run_frame(0, 255, 61, FILL_CAPTURE, FLOW_FREE, 1'b1, 1'b0);

      $display("Ran %0d pixel requests with %0d frame-end reports checked.",
               requests_sent, frame_reports);
      $display("Narrow, full and empty bands; frame sizes changed between rows; long hold.");
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/dbmcr_pkg.sv
rtl/dbmcr_ram.sv
rtl/dbmcr_div.sv
rtl/dbmcr_ctrl.sv
rtl/dbmcr_datapath.sv
rtl/disparity_band_mask_change_ratio.sv
tb/sv/disparity_band_mask_change_ratio_checker.sv
tb/sv/disparity_band_mask_change_ratio_test.sv
